### sv/tdma_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdma_pkg
// Shared widths, constants, types and the sample conversion used by the
// time-of-day moving average.
// ----------------------------------------------------------------------------
package tdma_pkg;

  localparam int HOUR_W         = 5;
  localparam int MIN_W          = 6;
  localparam int SEC_W          = 6;
  localparam int LEN_W          = 7;
  localparam int SAMPLE_W       = 17;
  localparam int MAX_WINDOW_DEF = 64;
  localparam int SEC_PER_HOUR   = 3600;
  localparam int SEC_PER_MIN    = 60;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIVIDE
  } tdma_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  // Seconds since midnight; raw field values are used without range checks.
  function automatic logic [SAMPLE_W-1:0] to_seconds(
    input logic [HOUR_W-1:0] h,
    input logic [MIN_W-1:0]  m,
    input logic [SEC_W-1:0]  s
  );
    logic [SAMPLE_W:0] total;
    total = (SAMPLE_W+1)'(h) * (SAMPLE_W+1)'(SEC_PER_HOUR)
          + (SAMPLE_W+1)'(m) * (SAMPLE_W+1)'(SEC_PER_MIN)
          + (SAMPLE_W+1)'(s);
    return total[SAMPLE_W-1:0];
  endfunction

endpackage

### sv/tdma_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdma_store
// Ring store of window samples: one write port and one read port with a
// registered read.
// ----------------------------------------------------------------------------
module tdma_store #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6,
  parameter int DATA_W = 17
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### sv/tdma_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdma_div
// Restoring divider, one quotient bit per cycle. The quotient stays in the
// shift register until the next start.
// ----------------------------------------------------------------------------
module tdma_div #(
  parameter int NUM_W = 23,
  parameter int DEN_W = 7
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [NUM_W-1:0]         dividend,
  input  logic [DEN_W-1:0]         divisor,
  output logic [NUM_W-1:0]         quotient,
  output tdma_pkg::div_status_t    status
);
  import tdma_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] dq;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [DEN_W:0]   rem_shift;
  logic [DEN_W+1:0] diff;
  logic             ge;

  assign rem_shift = {rem, dq[NUM_W-1]};
  assign diff      = {1'b0, rem_shift} - {2'b0, den};
  assign ge        = ~diff[DEN_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(NUM_W);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq  <= dividend;
      rem <= '0;
      den <= divisor;
    end else if (cnt != '0) begin
      dq  <= {dq[NUM_W-2:0], ge};
      rem <= ge ? diff[DEN_W-1:0] : rem_shift[DEN_W-1:0];
    end
  end

  assign quotient    = dq;
  assign status.busy = (cnt != '0);
  assign status.done = (cnt == '0);

endmodule

### sv/time_of_day_moving_average.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// time_of_day_moving_average
// Boxcar moving average of time-of-day samples held in a ring store.
//
//   Channel  Handshake                  Payload
//   input    in_valid / in_ready        hours, minutes, seconds, first
//   output   out_valid / out_ready      average
//   config   window_length_we           window_length
//
// An item passes the idle (accept) and update states, and, when it gives a
// result, the divide state, which waits on the divider and a free output.
// The store read is issued in the accept cycle and the write-back follows
// in the next, so successive items never touch the same entry in flight.
// A finished result waits in the output register while the next item runs.
// Reset empties the window and sets the window length to one; the store
// itself is not cleared.
// ----------------------------------------------------------------------------
module time_of_day_moving_average #(
  parameter int MAX_WINDOW = tdma_pkg::MAX_WINDOW_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          window_length_we,
  input  logic [tdma_pkg::LEN_W-1:0]    window_length,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tdma_pkg::HOUR_W-1:0]   hours,
  input  logic [tdma_pkg::MIN_W-1:0]    minutes,
  input  logic [tdma_pkg::SEC_W-1:0]    seconds,
  input  logic                          first,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tdma_pkg::SAMPLE_W-1:0] average
);
  import tdma_pkg::*;

  localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int N_W   = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = SAMPLE_W + $clog2(MAX_WINDOW);

  tdma_state_t state, state_next;

  logic [LEN_W-1:0]    wlen;
  logic [SUM_W-1:0]    sum;
  logic [SUM_W-1:0]    sum_next;
  logic [N_W-1:0]      fill;
  logic [N_W-1:0]      fill_next;
  logic [PTR_W-1:0]    wp;
  logic [PTR_W-1:0]    wp_next;
  logic [SAMPLE_W-1:0] sample;

  logic [N_W-1:0]      n;
  logic [LEN_W+N_W-1:0] wlen_ext;
  logic [PTR_W+1:0]    oldest_raw;
  logic [PTR_W-1:0]    oldest;
  logic [SAMPLE_W-1:0] old_sample;
  logic                full;

  logic                accept;
  logic                upd;
  logic                div_start;
  logic                out_load;
  logic                out_free;
  logic [SUM_W-1:0]    quotient;
  div_status_t         div_stat;

  // Effective window length: zero counts as one, too large clamps.
  assign wlen_ext = {{N_W{1'b0}}, wlen};
  always_comb begin
    if (wlen == '0) begin
      n = N_W'(1);
    end else if (int'(wlen) > MAX_WINDOW) begin
      n = N_W'(MAX_WINDOW);
    end else begin
      n = wlen_ext[N_W-1:0];
    end
  end

  // Oldest entry in the window, one wrap correction.
  always_comb begin
    oldest_raw = {2'b00, wp} + (PTR_W+2)'(MAX_WINDOW) - (PTR_W+2)'(n);
    if (oldest_raw >= (PTR_W+2)'(MAX_WINDOW)) begin
      oldest_raw = oldest_raw - (PTR_W+2)'(MAX_WINDOW);
    end
    oldest = oldest_raw[PTR_W-1:0];
  end

  assign full      = (fill >= n);
  assign sum_next  = sum - (full ? SUM_W'(old_sample) : '0) + SUM_W'(sample);
  assign fill_next = full ? fill : fill + 1'b1;
  assign wp_next   = (wp == PTR_W'(MAX_WINDOW - 1)) ? '0 : wp + 1'b1;
  assign out_free  = ~out_valid | out_ready;
  assign accept    = in_valid & in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_next = (fill_next >= n) ? ST_DIVIDE : ST_IDLE;
      end
      ST_DIVIDE: begin
        if (div_stat.done && out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    upd       = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_UPDATE: begin
        upd       = 1'b1;
        div_start = (fill_next >= n);
      end
      ST_DIVIDE: begin
        out_load = div_stat.done & out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wlen <= LEN_W'(1);
      sum  <= '0;
      fill <= '0;
      wp   <= '0;
    end else if (window_length_we) begin
      wlen <= window_length;
      sum  <= '0;
      fill <= '0;
    end else if (accept && first) begin
      sum  <= '0;
      fill <= '0;
    end else if (upd) begin
      sum  <= sum_next;
      fill <= fill_next;
      wp   <= wp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample <= to_seconds(hours, minutes, seconds);
    end
  end

  tdma_store #(
    .DEPTH  (MAX_WINDOW),
    .ADDR_W (PTR_W),
    .DATA_W (SAMPLE_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (upd),
    .wr_addr (wp),
    .wr_data (sample),
    .rd_en   (accept),
    .rd_addr (oldest),
    .rd_data (old_sample)
  );

  tdma_div #(
    .NUM_W (SUM_W),
    .DEN_W (N_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_next),
    .divisor  (n),
    .quotient (quotient),
    .status   (div_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      average <= quotient[SAMPLE_W-1:0];
    end
  end

endmodule

### sv/tdma_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdma_checker
// Port-level checks for the time-of-day moving average, bound to the top.
// ----------------------------------------------------------------------------
module tdma_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [tdma_pkg::SAMPLE_W-1:0] average
);
  import tdma_pkg::*;

  // A result that is not taken stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(average))
    else $error("result changed or dropped while stalled");

  // Only one transaction is in work at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again in the cycle after a transaction");

  // A result never appears in the cycle right after an input transaction.
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_valid && in_ready))
    else $error("result appeared too early after an input transaction");

  // Reset leaves the block empty and ready.
  a_reset_state: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not empty and ready after reset");

endmodule

bind time_of_day_moving_average tdma_checker u_tdma_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .average   (average)
);
